// ===== design/bbis_pkg.sv =====
// Shared constants and field widths for the bilinear byte image sampler.
package bbis_pkg;

  // Default store size and coordinate fraction width.
  localparam int DEF_STORE_BYTES   = 65536;
  localparam int DEF_FRACTION_BITS = 8;

  // Fixed field widths.
  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int CHAN_W  = 2;
  localparam int COORD_W = 20;
  localparam int DIM_W   = 11;
  localparam int LAYER_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS       = 2'd2;

  // Item operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

// ===== design/bbis_ram.sv =====
// Generic single-port RAM with registered read data.
module bbis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/bilinear_byte_image_sampler_core.sv =====
// Top level of the bilinear byte image sampler: byte store, sequencer and blend.
//
// The block keeps an interleaved 8-bit image in a single-port byte store of
// STORE_BYTES entries (a power of two; addresses wrap modulo its size). A
// write item (op = 0) stores one byte in the cycle it is accepted and the block
// can take another item on the next cycle; it returns no result. A sample item
// (op = 1) carries signed column and row coordinates with FRACTION_BITS fraction
// bits and a channel. The integer parts are floored and both neighbor columns
// and rows are clamped to the image edges, the four neighbor bytes are read at
// stride * row + layers * col + channel, with the row stride equal to
// image_width * layers rounded up to a multiple of 4, and the bytes are blended
// with weights built from the fractional parts. The blend is truncated and
// clamped to 0..255. A sample item holds the input stalled after it is accepted:
// a preparation step forms row bases and weights, read steps in which the
// single store port delivers one neighbor per cycle feed a multiply and an
// accumulate stage, and a last step loads the result register. The result
// register decouples the output: writes keep flowing while a result waits, and
// a later sample only holds in its last step until that register is free.
// Registers are written through cfg_write/cfg_index/cfg_data while no item is in
// flight; a width or height of 0 acts as 1. The store has no reset; read only
// entries that were written.
module bilinear_byte_image_sampler_core
  import bbis_pkg::*;
#(
  parameter int STORE_BYTES   = DEF_STORE_BYTES,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  // input item channel
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      op,
  input  logic [ADDR_W-1:0]         address,
  input  logic [BYTE_W-1:0]         write_data,
  input  logic [CHAN_W-1:0]         channel,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  // result channel
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [BYTE_W-1:0]         sample_value,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(STORE_BYTES);
  localparam int F     = FRACTION_BITS;
  localparam int FLW   = COORD_W - F;       // floored coordinate width
  localparam int POSW  = 22;                // signed compare width for the clamp
  localparam int STRW  = 14;                // row stride width
  localparam int RBW   = STRW + DIM_W;      // row base width
  localparam int COW   = LAYER_W + DIM_W;   // column offset width
  localparam int SUMW  = RBW + 1;           // full byte address width
  localparam int WTW   = 2 * F + 1;         // corner weight width
  localparam int PRW   = WTW + BYTE_W;      // weighted byte width
  localparam int ACCW  = 2 * F + BYTE_W + 2;
  localparam int CNT_W = 3;

  localparam logic [CNT_W-1:0] STEP_LAST_READ = 3'd3;
  localparam logic [CNT_W-1:0] STEP_LAST      = 3'd5;
  localparam logic [F:0]       SCALE          = {1'b1, {F{1'b0}}};
  localparam logic [ACCW-1:0]  ACC_TOP        = ACCW'(255) << (2 * F);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_DONE
  } state_t;

  // Clamp a neighbor position into 0..size-1.
  function automatic logic [DIM_W-1:0] edge_clamp(input logic signed [POSW-1:0] pos,
                                                  input logic [DIM_W-1:0] size);
    logic signed [POSW-1:0] lim;
    lim = $signed({{(POSW - DIM_W){1'b0}}, size});
    if (pos < 0) begin
      return '0;
    end else if (pos >= lim) begin
      return size - DIM_W'(1);
    end else begin
      return pos[DIM_W-1:0];
    end
  endfunction

  state_t state;
  logic [CNT_W-1:0] step;

  // configuration
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [LAYER_W-1:0] layers;
  logic [DIM_W-1:0]   width_eff;
  logic [DIM_W-1:0]   height_eff;
  logic [STRW-1:0]    stride;
  logic [STRW:0]      stride_raw;

  // per-sample registers
  logic [CHAN_W-1:0] chan;
  logic [F-1:0]      tx;
  logic [F-1:0]      ty;
  logic [DIM_W-1:0]  col0, col1, row0, row1;
  logic [RBW-1:0]    row_base0, row_base1;
  logic [COW-1:0]    col_ofs0, col_ofs1;
  logic [WTW-1:0]    weight00, weight01, weight10, weight11;
  logic [WTW-1:0]    weight;
  logic [WTW-1:0]    weight_dly;
  logic [PRW-1:0]    product;
  logic [ACCW-1:0]   acc;

  // accept-time clamp
  logic signed [FLW-1:0]  x_floor, y_floor;
  logic signed [POSW-1:0] x_pos, y_pos;
  logic item_take;
  logic sample_take;

  // store port
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [SUMW-1:0]   rd_sum;
  logic [AW+SUMW-1:0]   rd_ext;
  logic [AW+ADDR_W-1:0] wr_ext;
  logic              issue_read;

  // blend inputs
  logic [F:0] wx0, wy0, wx1, wy1;
  logic       result_free;

  assign item_stall  = (state != ST_IDLE);
  assign item_take   = item_valid && !item_stall;
  assign sample_take = item_take && (op == OP_SAMPLE);
  assign ram_we      = item_take && (op == OP_WRITE);

  assign width_eff  = (image_width == '0) ? DIM_W'(1) : image_width;
  assign height_eff = (image_height == '0) ? DIM_W'(1) : image_height;
  assign stride_raw = (STRW + 1)'(width_eff * layers) + (STRW + 1)'(3);

  // Floor is the integer bit field of the coordinate.
  assign x_floor = x_coord[COORD_W-1:F];
  assign y_floor = y_coord[COORD_W-1:F];
  assign x_pos   = POSW'(x_floor);
  assign y_pos   = POSW'(y_floor);

  assign wx0 = SCALE - {1'b0, tx};
  assign wx1 = {1'b0, tx};
  assign wy0 = SCALE - {1'b0, ty};
  assign wy1 = {1'b0, ty};

  // Read order: top-left, top-right, bottom-left, bottom-right.
  assign issue_read = (state == ST_READ) && (step <= STEP_LAST_READ);
  assign rd_sum = (step[1] ? SUMW'(row_base1) : SUMW'(row_base0))
                + (step[0] ? SUMW'(col_ofs1) : SUMW'(col_ofs0))
                + SUMW'(chan);
  assign rd_ext = {{AW{1'b0}}, rd_sum};
  assign wr_ext = {{AW{1'b0}}, address};
  assign ram_addr = issue_read ? rd_ext[AW-1:0] : wr_ext[AW-1:0];

  always_comb begin
    case (step[1:0])
      2'd0:    weight = weight00;
      2'd1:    weight = weight01;
      2'd2:    weight = weight10;
      2'd3:    weight = weight11;
      default: weight = weight00;
    endcase
  end

  assign result_free = !result_valid || !result_stall;

  bbis_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (write_data),
    .rdata (ram_rdata)
  );

  // Configuration registers and the derived row stride.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
      layers       <= LAYER_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_LAYERS:       layers       <= cfg_data[LAYER_W-1:0];
        default:          ;
      endcase
    end
    // round up to a multiple of 4
    stride <= {stride_raw[STRW-1:2], 2'b00};
  end

  // Sequencer, datapath and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      // drop the result once it is taken, unless a new one replaces it
      if (result_valid && !result_stall && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_take) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          step  <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          step <= step + CNT_W'(1);
          if (step == STEP_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the result register is free
          if (result_free) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end

    // latch the sample: fractions and clamped neighbors
    if (sample_take) begin
      chan <= channel;
      tx   <= x_coord[F-1:0];
      ty   <= y_coord[F-1:0];
      col0 <= edge_clamp(x_pos, width_eff);
      col1 <= edge_clamp(x_pos + POSW'(1), width_eff);
      row0 <= edge_clamp(y_pos, height_eff);
      row1 <= edge_clamp(y_pos + POSW'(1), height_eff);
    end

    if (state == ST_PREP) begin
      row_base0 <= RBW'(stride * row0);
      row_base1 <= RBW'(stride * row1);
      col_ofs0  <= COW'(layers * col0);
      col_ofs1  <= COW'(layers * col1);
      weight00  <= WTW'(wy0 * wx0);
      weight01  <= WTW'(wy0 * wx1);
      weight10  <= WTW'(wy1 * wx0);
      weight11  <= WTW'(wy1 * wx1);
      acc       <= '0;
    end

    if (state == ST_READ) begin
      // weighted byte registered from the read data, then added to the accumulator
      product <= PRW'(ram_rdata * weight_dly);
      if (step >= CNT_W'(2)) begin
        acc <= acc + ACCW'(product);
      end
    end

    if (state == ST_DONE && result_free) begin
      sample_value <= (acc > ACC_TOP) ? BYTE_W'(255) : acc[2*F+BYTE_W-1:2*F];
    end
  end

  // Weight is registered alongside its read so it meets the registered read data.
  always_ff @(posedge clk) begin
    if (issue_read) begin
      weight_dly <= weight;
    end
  end

  // Store writes happen only between samples.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE))
    else $error("store write while a sample is in flight");

  // The blend of four bytes never exceeds full scale.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (acc <= ACC_TOP))
    else $error("accumulated blend above full scale");

  // An accepted sample starts its preparation step next.
  assert property (@(posedge clk) disable iff (rst)
    sample_take |=> (state == ST_PREP))
    else $error("sample accepted but sequencer did not start");

  // A finished sample with a free result register is presented next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !result_valid) |=> (result_valid && state == ST_IDLE))
    else $error("finished sample not presented");

  // Reset leaves no result pending and the sequencer idle.
  assert property (@(posedge clk)
    rst |=> (!result_valid && state == ST_IDLE))
    else $error("reset did not clear the sequencer");

endmodule
